// ===== rtl/core/tgarle_pkg.sv =====
// ----------------------------------------------------------------------------
// tgarle_pkg
// Shared types and constants for the TGA run-length pixel decoder.
// ----------------------------------------------------------------------------
package tgarle_pkg;

  // Image dimension limits
  localparam logic [12:0] MAX_DIMENSION = 13'd4096;
  localparam logic [12:0] MIN_WIDTH     = 13'd4;
  localparam logic [12:0] MIN_HEIGHT    = 13'd1;

  // Command queue between front and back end
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // Configuration register indexes
  localparam logic [2:0] CFG_RLE_MODE        = 3'd0;
  localparam logic [2:0] CFG_BYTES_PER_PIXEL = 3'd1;
  localparam logic [2:0] CFG_IMAGE_WIDTH     = 3'd2;
  localparam logic [2:0] CFG_IMAGE_HEIGHT    = 3'd3;
  localparam logic [2:0] CFG_FLIP_ROWS       = 3'd4;

  // Packet phase of the run-length parser
  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_RAW    = 2'd1,
    PH_RUN    = 2'd2
  } phase_t;

  typedef struct packed {
    logic        rle_mode;
    logic [2:0]  bytes_per_pixel;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic        flip_rows;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       image_start;
  } in_item_t;

  typedef struct packed {
    logic [23:0] dest_index;
    logic [7:0]  span_length;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        span_last;
    logic        image_done;
  } out_item_t;

  // Pixel command: one assembled colour repeated count times
  typedef struct packed {
    logic       restart;
    logic [7:0] count;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== rtl/core/tga_rle_pixel_decoder.sv =====
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder
// TGA pixel-data decoder: uncompressed or run-length bytes in, RGBA row spans
// out.
// ----------------------------------------------------------------------------
// The decoder takes one pixel-data byte per cycle while its four-entry pixel
// command queue has room. Each completed source pixel (2, 3 or 4 bytes, or a
// whole run packet) becomes one command; the span emitter loads a command and
// then emits its spans, so a run that crosses row ends yields its spans at one
// per cycle while the output register is free and holds the byte input only
// once the queue fills. A result waits in an output register while new bytes
// keep arriving. Spans never cross a row end, carry the row-major destination
// index of their first pixel (rows reversed when flip is set), and the span
// that completes the last pixel carries image_done; everything after it is
// dropped until a byte with image_start. Configuration is written through a
// plain write port and takes effect on the next item; no clearing pass runs
// after reset.
module tga_rle_pixel_decoder (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [12:0]           cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  tgarle_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output tgarle_pkg::out_item_t out_data
);

  tgarle_pkg::cfg_t    cfg_r;
  tgarle_pkg::cmd_t    q_wdata, q_rdata;
  tgarle_pkg::q_stat_t q_stat;
  logic                q_push, q_pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rle_mode        <= 1'b0;
      cfg_r.bytes_per_pixel <= 3'd4;
      cfg_r.image_width     <= 13'd4096;
      cfg_r.image_height    <= 13'd4096;
      cfg_r.flip_rows       <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        tgarle_pkg::CFG_RLE_MODE:        cfg_r.rle_mode        <= cfg_data[0];
        tgarle_pkg::CFG_BYTES_PER_PIXEL: cfg_r.bytes_per_pixel <= cfg_data[2:0];
        tgarle_pkg::CFG_IMAGE_WIDTH:     cfg_r.image_width     <= cfg_data;
        tgarle_pkg::CFG_IMAGE_HEIGHT:    cfg_r.image_height    <= cfg_data;
        tgarle_pkg::CFG_FLIP_ROWS:       cfg_r.flip_rows       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Byte parser
  tgarle_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  // Command queue
  tgarle_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .stat      (q_stat)
  );

  // Span emitter
  tgarle_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_data    (q_rdata),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // A command is never pushed into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_stat.full))
    else $error("command pushed into full queue");

  // A command is never popped from an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_pop && q_stat.empty))
    else $error("command popped from empty queue");

  // Spans hold 1 to 128 pixels
  a_span_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.span_length != 8'd0 && out_data.span_length <= 8'd128))
    else $error("span length out of range");

  // The image-done span ends its transfer group
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.image_done) |-> out_data.span_last)
    else $error("image_done without span_last");
`endif

endmodule

// ===== rtl/core/tgarle_front.sv =====
// ----------------------------------------------------------------------------
// tgarle_front
// Byte parser: packet headers, pixel byte assembly and BGR(A) to RGBA
// conversion. Pushes one pixel command per completed source pixel.
// ----------------------------------------------------------------------------
module tgarle_front (
  input  logic                clk,
  input  logic                rst_n,
  input  tgarle_pkg::cfg_t    cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  tgarle_pkg::in_item_t in_data,
  input  tgarle_pkg::q_stat_t q_stat,
  output logic                q_push,
  output tgarle_pkg::cmd_t    q_data
);

  logic [7:0]         buf_r [4];
  logic [1:0]         pos_r, pos_nxt;
  tgarle_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]         rem_r, rem_nxt;
  logic               pend_r, pend_nxt;

  logic               accept;
  logic               buf_we;
  logic [1:0]         pos_cur;
  tgarle_pkg::phase_t phase_cur;
  logic [7:0]         rem_cur;
  logic [7:0]         rem_dec;
  logic [2:0]         nbytes;
  logic [7:0]         b0, b1, b2, b3;
  logic [7:0]         byte_in;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign byte_in  = in_data.data_byte;

  // Source pixel size; codes other than 2 and 3 act as 4 bytes
  always_comb begin
    case (cfg.bytes_per_pixel)
      3'd2:    nbytes = 3'd2;
      3'd3:    nbytes = 3'd3;
      default: nbytes = 3'd4;
    endcase
  end

  // Start of image restarts the parser before this byte is taken
  assign pos_cur   = in_data.image_start ? 2'd0 : pos_r;
  assign phase_cur = in_data.image_start ? tgarle_pkg::PH_HEADER : phase_r;
  assign rem_cur   = in_data.image_start ? 8'd0 : rem_r;
  assign rem_dec   = (rem_cur != 8'd0) ? rem_cur - 8'd1 : 8'd0;

  // Pixel bytes with the incoming byte in its slot
  assign b0 = (pos_cur == 2'd0) ? byte_in : buf_r[0];
  assign b1 = (pos_cur == 2'd1) ? byte_in : buf_r[1];
  assign b2 = (pos_cur == 2'd2) ? byte_in : buf_r[2];
  assign b3 = (pos_cur == 2'd3) ? byte_in : buf_r[3];

  // Colour conversion
  always_comb begin
    q_data.restart = pend_r || in_data.image_start;
    q_data.count   = 8'd1;
    if (nbytes == 3'd2) begin
      q_data.red   = {b1[6:2], 3'b000};
      q_data.green = {b1[1:0], b0[7:5], 3'b000};
      q_data.blue  = {b0[4:0], 3'b000};
      q_data.alpha = b1 & 8'h80;
    end else begin
      q_data.red   = b2;
      q_data.green = b1;
      q_data.blue  = b0;
      q_data.alpha = (nbytes == 3'd3) ? 8'd255 : b3;
    end
    if (cfg.rle_mode && phase_cur == tgarle_pkg::PH_RUN) begin
      q_data.count = rem_cur;
    end
  end

  // Packet phase and byte position
  always_comb begin
    pos_nxt   = pos_r;
    phase_nxt = phase_r;
    rem_nxt   = rem_r;
    pend_nxt  = pend_r;
    buf_we    = 1'b0;
    q_push    = 1'b0;
    if (accept) begin
      pos_nxt   = pos_cur;
      phase_nxt = phase_cur;
      rem_nxt   = rem_cur;
      if (in_data.image_start) begin
        pend_nxt = 1'b1;
      end
      if (cfg.rle_mode && phase_cur == tgarle_pkg::PH_HEADER) begin
        // packet header byte
        rem_nxt   = {1'b0, byte_in[6:0]} + 8'd1;
        phase_nxt = byte_in[7] ? tgarle_pkg::PH_RUN : tgarle_pkg::PH_RAW;
        pos_nxt   = 2'd0;
      end else begin
        buf_we = 1'b1;
        if (({1'b0, pos_cur} + 3'd1) < nbytes) begin
          pos_nxt = pos_cur + 2'd1;
        end else begin
          pos_nxt  = 2'd0;
          q_push   = 1'b1;
          pend_nxt = 1'b0;
          if (cfg.rle_mode) begin
            case (phase_cur)
              tgarle_pkg::PH_RUN: begin
                rem_nxt   = 8'd0;
                phase_nxt = tgarle_pkg::PH_HEADER;
              end
              tgarle_pkg::PH_RAW: begin
                rem_nxt = rem_dec;
                if (rem_dec == 8'd0) begin
                  phase_nxt = tgarle_pkg::PH_HEADER;
                end
              end
              default: phase_nxt = tgarle_pkg::PH_HEADER;
            endcase
          end
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= 2'd0;
      phase_r <= tgarle_pkg::PH_HEADER;
      rem_r   <= 8'd0;
      pend_r  <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      phase_r <= phase_nxt;
      rem_r   <= rem_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // Pixel byte buffer
  always_ff @(posedge clk) begin
    if (buf_we) begin
      buf_r[pos_cur] <= byte_in;
    end
  end

endmodule

// ===== rtl/core/tgarle_fifo.sv =====
// ----------------------------------------------------------------------------
// tgarle_fifo
// Short command queue that decouples the byte parser from the span emitter.
// ----------------------------------------------------------------------------
module tgarle_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  tgarle_pkg::cmd_t    push_data,
  input  logic                pop,
  output tgarle_pkg::cmd_t    pop_data,
  output tgarle_pkg::q_stat_t stat
);

  tgarle_pkg::cmd_t           mem [tgarle_pkg::Q_DEPTH];
  logic [tgarle_pkg::Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [tgarle_pkg::Q_AW:0]   cnt_r;

  assign stat.full  = (cnt_r == (tgarle_pkg::Q_AW+1)'(tgarle_pkg::Q_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign pop_data   = mem[rd_ptr_r];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/core/tgarle_back.sv =====
// ----------------------------------------------------------------------------
// tgarle_back
// Span emitter: splits each pixel command at row ends, tracks the row and
// column position, applies the vertical flip and flags the image end.
// ----------------------------------------------------------------------------
module tgarle_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tgarle_pkg::cfg_t     cfg,
  input  tgarle_pkg::cmd_t     q_data,
  input  tgarle_pkg::q_stat_t  q_stat,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tgarle_pkg::out_item_t out_data
);

  logic                  busy_r;
  tgarle_pkg::cmd_t      cmd_r;
  logic [11:0]           col_r;
  logic [23:0]           row_r;
  logic                  fin_r;
  logic [23:0]           last_base_r;
  logic                  out_valid_r;
  tgarle_pkg::out_item_t out_data_r;

  logic [12:0] w, h;
  logic [25:0] base_prod;
  logic        load, drop, fire, out_free;
  logic [12:0] col_ext, room, col_sum;
  logic [7:0]  n, cnt_left;
  logic [23:0] dest;
  logic        row_end, done, last;

  // Clamped dimensions
  always_comb begin
    if (cfg.image_width < tgarle_pkg::MIN_WIDTH) begin
      w = tgarle_pkg::MIN_WIDTH;
    end else if (cfg.image_width > tgarle_pkg::MAX_DIMENSION) begin
      w = tgarle_pkg::MAX_DIMENSION;
    end else begin
      w = cfg.image_width;
    end
    if (cfg.image_height < tgarle_pkg::MIN_HEIGHT) begin
      h = tgarle_pkg::MIN_HEIGHT;
    end else if (cfg.image_height > tgarle_pkg::MAX_DIMENSION) begin
      h = tgarle_pkg::MAX_DIMENSION;
    end else begin
      h = cfg.image_height;
    end
  end

  // Base index of the last row
  assign base_prod = (h - 13'd1) * w;

  always_ff @(posedge clk) begin
    last_base_r <= base_prod[23:0];
  end

  // Command handling
  assign out_free = !out_valid_r || out_ready;
  assign load     = !busy_r && !q_stat.empty;
  assign q_pop    = load;
  assign drop     = busy_r && (fin_r || cmd_r.count == 8'd0);
  assign fire     = busy_r && !drop && out_free;

  // Span length limited by the room left in the row
  assign col_ext  = {1'b0, col_r};
  assign room     = (col_ext < w) ? (w - col_ext) : 13'd1;
  assign n        = ({5'd0, cmd_r.count} < room) ? cmd_r.count : room[7:0];
  assign col_sum  = col_ext + {5'd0, n};
  assign cnt_left = cmd_r.count - n;
  assign row_end  = (col_sum >= w);
  assign done     = row_end && (row_r >= last_base_r);
  assign last     = (cnt_left == 8'd0) || done;
  assign dest     = cfg.flip_rows ? (last_base_r - row_r + {12'd0, col_r})
                                  : (row_r + {12'd0, col_r});

  // Position and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      col_r       <= 12'd0;
      row_r       <= 24'd0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        busy_r <= 1'b1;
        if (q_data.restart) begin
          col_r <= 12'd0;
          row_r <= 24'd0;
          fin_r <= 1'b0;
        end
      end else if (drop) begin
        busy_r <= 1'b0;
      end else if (fire) begin
        if (last) begin
          busy_r <= 1'b0;
        end
        if (row_end) begin
          col_r <= 12'd0;
          if (done) begin
            fin_r <= 1'b1;
          end else begin
            row_r <= row_r + {11'd0, w};
          end
        end else begin
          col_r <= col_sum[11:0];
        end
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Command and output payload
  always_ff @(posedge clk) begin
    if (load) begin
      cmd_r <= q_data;
    end else if (fire) begin
      cmd_r.count <= cnt_left;
    end
    if (fire) begin
      out_data_r.dest_index  <= dest;
      out_data_r.span_length <= n;
      out_data_r.red         <= cmd_r.red;
      out_data_r.green       <= cmd_r.green;
      out_data_r.blue        <= cmd_r.blue;
      out_data_r.alpha       <= cmd_r.alpha;
      out_data_r.span_last   <= last;
      out_data_r.image_done  <= done;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
